/* src/cle_pkg.sv */
// Shared types and constants for the console line editor.
package cle_pkg;
   localparam int LINE_DEPTH = 16;
   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int CNT_W = $clog2(LINE_DEPTH + 1);

   localparam logic [6:0] CH_BS = 7'd8;
   localparam logic [6:0] CH_LF = 7'd10;
   localparam logic [6:0] CH_CR = 7'd13;
   localparam logic [6:0] CH_ESC = 7'd27;
   localparam logic [6:0] CH_SPACE = 7'd32;
   localparam logic [6:0] CH_A = 7'd65;
   localparam logic [6:0] CH_B = 7'd66;
   localparam logic [6:0] CH_C = 7'd67;
   localparam logic [6:0] CH_D = 7'd68;
   localparam logic [6:0] CH_BRACKET = 7'd91;
   localparam logic [6:0] CH_DEL = 7'd127;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_CHAR = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;
   localparam logic [1:0] KIND_ABORT = 2'd3;

   localparam logic [2:0] REG_ALLOW_LO = 3'd0;
   localparam logic [2:0] REG_ALLOW_HI = 3'd1;
   localparam logic [2:0] REG_END_LO = 3'd2;
   localparam logic [2:0] REG_END_HI = 3'd3;
   localparam logic [2:0] REG_MAX = 3'd4;
   localparam logic [2:0] REG_MODE = 3'd5;
   localparam logic [2:0] REG_LCHAR = 3'd6;
   localparam logic [2:0] REG_QUOTA = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SHIFT_R,
      ST_INS_ECHO,
      ST_INS_BS,
      ST_SHIFT_L,
      ST_DEL_TAIL,
      ST_DEL_SP,
      ST_DEL_BS,
      ST_DEL_BS_TAIL,
      ST_LF,
      ST_DELIVER,
      ST_END,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] data;
      logic [4:0] length;
      logic       last;
   } rsp_type;

   // memory access request from sequencer
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [6:0]        wr_data;
   } mem_req_type;
endpackage

/* src/cle_if.sv */
// Valid/ready channel interfaces.
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [6:0] out_byte;
   logic [4:0] line_length;
   logic       last_of_run;
   modport source (output valid, output out_kind, output out_byte, output line_length,
                   output last_of_run, input ready);
   modport sink (input valid, input out_kind, input out_byte, input line_length,
                 input last_of_run, output ready);
endinterface

interface cle_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* src/cle_line_ram.sv */
// Line store memory, one write and one registered read port.
module cle_line_ram (
   input  logic                clock,
   input  cle_pkg::mem_req_type req,
   output logic [6:0]          rd_data
);
   logic [6:0] mem [cle_pkg::LINE_DEPTH];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/cle_out_reg.sv */
// Output register between the sequencer and the result channel.
module cle_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cle_pkg::rsp_type   in_data,
   cle_rsp_if.source          rsp
);
   logic             valid_ff;
   cle_pkg::rsp_type data_ff;

   assign in_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.out_kind = data_ff.kind;
   assign rsp.out_byte = data_ff.data;
   assign rsp.line_length = data_ff.length;
   assign rsp.last_of_run = data_ff.last;
endmodule

/* src/console_line_editor.sv */
// Console line editor top level: sequencer around the line store memory.
// An accepted byte is decoded in ST_DECIDE; an insertion first shifts the line right in
// ST_SHIFT_R; then one result per cycle leaves through the output register when not stalled.
// A new byte is taken only in ST_IDLE, once the walk of the line store is done (shift,
// redraw and delivery one entry a cycle, the latter two when the output is not stalled).
// Reset: synchronous; registers return to defaults, line and cursor clear.
module console_line_editor (
   input  logic      clock,
   input  logic      reset,
   cle_req_if.sink   req,
   cle_rsp_if.source rsp,
   cle_csr_if.sink   csr
);
   localparam int AW = cle_pkg::ADDR_W;
   localparam int CW = cle_pkg::CNT_W;

   logic [63:0] allow_lo_ff, allow_hi_ff, end_lo_ff, end_hi_ff;
   logic [4:0]  max_ff;
   logic [3:0]  mode_ff;
   logic [6:0]  lchar_ff;
   logic [7:0]  quota_ff;

   cle_pkg::state_type state_ff, state_in, after_ff, after_in;
   logic [CW-1:0] count_ff, count_in, cursor_ff, cursor_in, idx_ff, idx_in, len_ff, len_in;
   logic [1:0]    esc_ff, esc_in;
   logic [7:0]    left_ff, left_in;
   logic [6:0]    ch_ff, ch_in;
   logic [6:0]    hold_ff, hold_in;
   logic          pend_ff, pend_in;
   // pending single result for ST_EMIT
   cle_pkg::rsp_type one_ff, one_in;

   cle_pkg::mem_req_type mreq;
   logic [6:0]           rd_data;
   logic                 o_valid, o_ready;
   cle_pkg::rsp_type     o_data;
   logic                 quota_wr;
   logic [CW-1:0]        limit;
   logic                 in_end, in_allow, is_lim;

   cle_line_ram u_ram (.clock(clock), .req(mreq), .rd_data(rd_data));
   cle_out_reg u_out (.clock(clock), .reset(reset), .in_valid(o_valid), .in_ready(o_ready),
                      .in_data(o_data), .rsp(rsp));

   assign csr.ready = 1'b1;
   assign quota_wr = csr.valid && csr.index == cle_pkg::REG_QUOTA;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_lo_ff <= 64'hFFFF_FFFF_F7FF_FAFF;
         allow_hi_ff <= 64'h7FFF_FFFF_FFFF_FFFF;
         end_lo_ff <= 64'd1024;
         end_hi_ff <= '0;
         max_ff <= '0;
         mode_ff <= 4'd3;
         lchar_ff <= '0;
         quota_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            cle_pkg::REG_ALLOW_LO: allow_lo_ff <= csr.data;
            cle_pkg::REG_ALLOW_HI: allow_hi_ff <= csr.data;
            cle_pkg::REG_END_LO: end_lo_ff <= csr.data;
            cle_pkg::REG_END_HI: end_hi_ff <= csr.data;
            cle_pkg::REG_MAX: max_ff <= csr.data[4:0];
            cle_pkg::REG_MODE: mode_ff <= csr.data[3:0];
            cle_pkg::REG_LCHAR: lchar_ff <= csr.data[6:0];
            cle_pkg::REG_QUOTA: quota_ff <= csr.data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (max_ff == 5'd0 || 32'(max_ff) > cle_pkg::LINE_DEPTH) begin
         limit = CW'(cle_pkg::LINE_DEPTH);
      end else begin
         limit = CW'(max_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cle_pkg::ST_IDLE;
         after_ff <= cle_pkg::ST_IDLE;
         count_ff <= '0;
         cursor_ff <= '0;
         esc_ff <= '0;
         left_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         count_ff <= count_in;
         cursor_ff <= cursor_in;
         esc_ff <= esc_in;
         left_ff <= quota_wr ? csr.data[7:0] : left_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      ch_ff <= ch_in;
      hold_ff <= hold_in;
      one_ff <= one_in;
   end

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      count_in = count_ff;
      cursor_in = cursor_ff;
      esc_in = esc_ff;
      left_in = left_ff;
      pend_in = pend_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      ch_in = ch_ff;
      hold_in = hold_ff;
      one_in = one_ff;
      req.ready = 1'b0;
      mreq = '0;
      o_valid = 1'b0;
      o_data = '0;
      in_end = 1'b0;
      in_allow = 1'b0;
      is_lim = 1'b0;
      case (state_ff)
         cle_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid && !req.rx_byte[7]) begin
               ch_in = req.rx_byte[6:0];
               state_in = cle_pkg::ST_DECIDE;
               // prefetch entry at cursor for right move
               mreq.rd_en = 1'b1;
               mreq.rd_addr = cursor_ff[AW-1:0];
            end
         end
         cle_pkg::ST_DECIDE: begin
            state_in = cle_pkg::ST_IDLE;
            one_in = '{kind: cle_pkg::KIND_ECHO, data: '0, length: '0, last: 1'b1};
            if (esc_ff == 2'd1) begin
               if (ch_ff == cle_pkg::CH_BRACKET) begin
                  esc_in = 2'd2;
               end else begin
                  esc_in = 2'd0;
                  if (mode_ff[2]) begin
                     one_in.kind = cle_pkg::KIND_ABORT;
                     state_in = cle_pkg::ST_EMIT;
                     count_in = '0;
                     cursor_in = '0;
                     left_in = quota_ff;
                  end
               end
            end else if (esc_ff == 2'd2) begin
               esc_in = 2'd0;
               if (ch_ff == cle_pkg::CH_C) begin
                  if (cursor_ff < count_ff && 32'(cursor_ff) < cle_pkg::LINE_DEPTH) begin
                     one_in.data = rd_data;
                     cursor_in = cursor_ff + 1'b1;
                     state_in = cle_pkg::ST_EMIT;
                  end
               end else if (ch_ff == cle_pkg::CH_D) begin
                  if (cursor_ff != '0) begin
                     one_in.data = cle_pkg::CH_BS;
                     cursor_in = cursor_ff - 1'b1;
                     state_in = cle_pkg::ST_EMIT;
                  end
               end else if (ch_ff != cle_pkg::CH_A && ch_ff != cle_pkg::CH_B) begin
                  if (mode_ff[2]) begin
                     one_in.kind = cle_pkg::KIND_ABORT;
                     state_in = cle_pkg::ST_EMIT;
                     count_in = '0;
                     cursor_in = '0;
                     left_in = quota_ff;
                  end
               end
            end else begin
               hold_in = (ch_ff == cle_pkg::CH_CR) ? cle_pkg::CH_LF : ch_ff;
               in_end = hold_in[6] ? end_hi_ff[hold_in[5:0]] : end_lo_ff[hold_in[5:0]];
               in_allow = hold_in[6] ? allow_hi_ff[hold_in[5:0]] :
                                       allow_lo_ff[hold_in[5:0]];
               is_lim = quota_ff != 8'd0 && hold_in == lchar_ff;
               if (is_lim && left_ff == 8'd0) begin
                  in_allow = 1'b0;
               end
               len_in = count_ff;
               idx_in = '0;
               if (in_end) begin
                  state_in = mode_ff[3] ? cle_pkg::ST_DELIVER : cle_pkg::ST_LF;
                  after_in = cle_pkg::ST_DELIVER;
                  pend_in = 1'b1;
                  mreq.rd_en = 1'b1;
                  mreq.rd_addr = '0;
               end else if (in_allow) begin
                  if (is_lim) begin
                     left_in = left_ff - 1'b1;
                  end
                  if (32'(count_ff) < cle_pkg::LINE_DEPTH && cursor_ff <= count_ff) begin
                     idx_in = count_ff;
                     state_in = cle_pkg::ST_SHIFT_R;
                     if (count_ff != cursor_ff) begin
                        mreq.rd_en = 1'b1;
                        mreq.rd_addr = AW'(count_ff - 1'b1);
                     end
                  end
               end else if (ch_ff == cle_pkg::CH_ESC) begin
                  esc_in = 2'd1;
               end else if (hold_in == cle_pkg::CH_BS || hold_in == cle_pkg::CH_DEL) begin
                  if (mode_ff[1] && cursor_ff != '0 && cursor_ff <= count_ff) begin
                     cursor_in = cursor_ff - 1'b1;
                     count_in = count_ff - 1'b1;
                     idx_in = cursor_ff - 1'b1;
                     state_in = cle_pkg::ST_SHIFT_L;
                     mreq.rd_en = 1'b1;
                     mreq.rd_addr = cursor_ff[AW-1:0];
                  end
               end
            end
         end
         // shift right one entry per cycle: rd_data holds entry idx-1
         cle_pkg::ST_SHIFT_R: begin
            if (idx_ff == cursor_ff) begin
               mreq.wr_en = 1'b1;
               mreq.wr_addr = cursor_ff[AW-1:0];
               mreq.wr_data = hold_ff;
               cursor_in = cursor_ff + 1'b1;
               count_in = count_ff + 1'b1;
               idx_in = cursor_ff;
               mreq.rd_en = 1'b0;
               if (mode_ff[0]) begin
                  state_in = cle_pkg::ST_INS_ECHO;
               end else begin
                  state_in = cle_pkg::ST_INS_BS;
                  idx_in = count_ff + 1'b1;
               end
            end else begin
               mreq.wr_en = 1'b1;
               mreq.wr_addr = idx_ff[AW-1:0];
               mreq.wr_data = rd_data;
               idx_in = idx_ff - 1'b1;
               if (idx_ff - 1'b1 != cursor_ff) begin
                  mreq.rd_en = 1'b1;
                  mreq.rd_addr = AW'(idx_ff - 2'd2);
               end
            end
         end
         // echo entries cursor-1 .. count-1; first uses held char
         cle_pkg::ST_INS_ECHO: begin
            o_valid = 1'b1;
            o_data.kind = cle_pkg::KIND_ECHO;
            o_data.data = (idx_ff == cursor_ff - 1'b1) ? hold_ff : rd_data;
            if (o_ready) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 < count_ff) begin
                  mreq.rd_en = 1'b1;
                  mreq.rd_addr = AW'(idx_ff + 1'b1);
               end
               if (idx_ff + 1'b1 == count_ff) begin
                  idx_in = cursor_ff;
                  state_in = cle_pkg::ST_INS_BS;
               end
            end
            if (idx_ff == cursor_ff - 1'b1) begin
               o_data.data = hold_ff;
            end
            o_data.last = idx_ff + 1'b1 == count_ff && cursor_ff == count_ff
                          && count_ff < limit;
            if (o_ready && o_data.last) begin
               state_in = cle_pkg::ST_IDLE;
            end
         end
         cle_pkg::ST_INS_BS: begin
            if (idx_ff >= count_ff || !mode_ff[0]) begin
               if (count_ff >= limit) begin
                  len_in = count_ff;
                  idx_in = '0;
                  after_in = cle_pkg::ST_END;
                  state_in = cle_pkg::ST_DELIVER;
                  pend_in = 1'b0;
                  mreq.rd_en = 1'b1;
                  mreq.rd_addr = '0;
               end else begin
                  state_in = cle_pkg::ST_IDLE;
               end
            end else begin
               o_valid = 1'b1;
               o_data.kind = cle_pkg::KIND_ECHO;
               o_data.data = cle_pkg::CH_BS;
               o_data.last = idx_ff + 1'b1 == count_ff && count_ff < limit;
               if (o_ready) begin
                  idx_in = idx_ff + 1'b1;
                  if (o_data.last) begin
                     state_in = cle_pkg::ST_IDLE;
                  end
               end
            end
         end
         // shift left: rd_data holds entry idx+1
         cle_pkg::ST_SHIFT_L: begin
            if (idx_ff >= count_ff) begin
               o_valid = 1'b1;
               o_data.kind = cle_pkg::KIND_ECHO;
               o_data.data = cle_pkg::CH_BS;
               o_data.last = !mode_ff[0];
               if (o_ready) begin
                  idx_in = cursor_ff;
                  if (!mode_ff[0]) begin
                     state_in = cle_pkg::ST_IDLE;
                  end else if (cursor_ff < count_ff) begin
                     state_in = cle_pkg::ST_DEL_TAIL;
                     mreq.rd_en = 1'b1;
                     mreq.rd_addr = cursor_ff[AW-1:0];
                  end else begin
                     state_in = cle_pkg::ST_DEL_SP;
                  end
               end
            end else begin
               mreq.wr_en = 1'b1;
               mreq.wr_addr = idx_ff[AW-1:0];
               mreq.wr_data = rd_data;
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 < count_ff) begin
                  mreq.rd_en = 1'b1;
                  mreq.rd_addr = AW'(idx_ff + 2'd2);
               end
            end
         end
         cle_pkg::ST_DEL_TAIL: begin
            o_valid = 1'b1;
            o_data.kind = cle_pkg::KIND_ECHO;
            o_data.data = rd_data;
            if (o_ready) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 < count_ff) begin
                  mreq.rd_en = 1'b1;
                  mreq.rd_addr = AW'(idx_ff + 1'b1);
               end else begin
                  state_in = cle_pkg::ST_DEL_SP;
               end
            end else begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = idx_ff[AW-1:0];
            end
         end
         cle_pkg::ST_DEL_SP: begin
            o_valid = 1'b1;
            o_data.kind = cle_pkg::KIND_ECHO;
            o_data.data = cle_pkg::CH_SPACE;
            if (o_ready) begin
               state_in = cle_pkg::ST_DEL_BS;
            end
         end
         cle_pkg::ST_DEL_BS: begin
            o_valid = 1'b1;
            o_data.kind = cle_pkg::KIND_ECHO;
            o_data.data = cle_pkg::CH_BS;
            o_data.last = cursor_ff == count_ff;
            if (o_ready) begin
               idx_in = cursor_ff;
               state_in = o_data.last ? cle_pkg::ST_IDLE : cle_pkg::ST_DEL_BS_TAIL;
            end
         end
         cle_pkg::ST_DEL_BS_TAIL: begin
            o_valid = 1'b1;
            o_data.kind = cle_pkg::KIND_ECHO;
            o_data.data = cle_pkg::CH_BS;
            o_data.last = idx_ff + 1'b1 == count_ff;
            if (o_ready) begin
               idx_in = idx_ff + 1'b1;
               if (o_data.last) begin
                  state_in = cle_pkg::ST_IDLE;
               end
            end
         end
         cle_pkg::ST_LF: begin
            o_valid = 1'b1;
            o_data.kind = cle_pkg::KIND_ECHO;
            o_data.data = cle_pkg::CH_LF;
            mreq.rd_en = 1'b1;
            mreq.rd_addr = '0;
            if (o_ready) begin
               state_in = after_ff;
            end
         end
         // deliver entries 0..len-1, rd_data holds entry idx
         cle_pkg::ST_DELIVER: begin
            if (idx_ff >= len_ff) begin
               if (pend_ff || mode_ff[3]) begin
                  state_in = cle_pkg::ST_END;
               end else begin
                  pend_in = 1'b1;
                  after_in = cle_pkg::ST_END;
                  state_in = cle_pkg::ST_LF;
               end
            end else begin
               o_valid = 1'b1;
               o_data.kind = cle_pkg::KIND_CHAR;
               o_data.data = rd_data;
               mreq.rd_en = 1'b1;
               mreq.rd_addr = idx_ff[AW-1:0];
               if (o_ready) begin
                  idx_in = idx_ff + 1'b1;
                  mreq.rd_addr = AW'(idx_ff + 1'b1);
               end
            end
         end
         cle_pkg::ST_END: begin
            o_valid = 1'b1;
            o_data.kind = cle_pkg::KIND_END;
            o_data.length = 5'(len_ff);
            o_data.last = 1'b1;
            if (o_ready) begin
               count_in = '0;
               cursor_in = '0;
               esc_in = '0;
               left_in = quota_ff;
               state_in = cle_pkg::ST_IDLE;
            end
         end
         cle_pkg::ST_EMIT: begin
            o_valid = 1'b1;
            o_data = one_ff;
            if (o_ready) begin
               state_in = cle_pkg::ST_IDLE;
            end
         end
         default: state_in = cle_pkg::ST_IDLE;
      endcase
   end
endmodule
